@@ src/wsenc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsenc_pkg
// Shared types, constants and the bit-pair symbol encoder of the pixel encoder.
// ----------------------------------------------------------------------------
package wsenc_pkg;

   // channel count and channel codes, in wire order
   localparam int NUM_CH = 3;
   localparam logic [1:0] CH_GREEN = 2'd0;
   localparam logic [1:0] CH_RED   = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // brightness after reset
   localparam logic [7:0] BRIGHT_RESET = 8'd40;

   // one spi byte for each pair of channel bits
   localparam logic [7:0] SYM_PAIR [4] = '{8'h88, 8'h8E, 8'hE8, 8'hEE};

   typedef logic [7:0]  color_type;
   typedef logic [31:0] word_type;
   typedef word_type    word_array_type [NUM_CH];

   // four spi bytes for one channel, msb pair in the top byte
   function automatic word_type encode_color(input color_type v);
      word_type w;
      w = '0;
      for (int k = 0; k < 4; k++) begin
         w = {w[23:0], SYM_PAIR[v[7 - 2*k -: 2]]};
      end
      return w;
   endfunction

endpackage

@@ src/wsenc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsenc channel interfaces
// Valid/ready channels for pixels, encoded words and the brightness register.
// ----------------------------------------------------------------------------

// pixel channel
interface wsenc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

// encoded word channel
interface wsenc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] spi_word;
   logic [1:0]  channel;
   logic        last_of_pixel;
   modport source (output valid, spi_word, channel, last_of_pixel, input ready);
   modport sink   (input valid, spi_word, channel, last_of_pixel, output ready);
endinterface

// brightness write channel
interface wsenc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] brightness;
   modport source (output valid, brightness, input ready);
   modport sink   (input valid, brightness, output ready);
endinterface

@@ src/wsenc_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsenc_lane
// One color lane: registered brightness product, divide by 255, symbol encode.
// ----------------------------------------------------------------------------
module wsenc_lane
   import wsenc_pkg::*;
(
   input  logic      clock,
   input  logic      load,
   input  color_type chan_value,
   input  color_type brightness,
   output word_type  enc_word
);

   logic [15:0] prod_ff;
   logic [15:0] prod_in;
   logic [15:0] quot_sum;
   color_type   scaled;

   // product of channel and brightness, captured with the pixel
   assign prod_in = 16'(chan_value) * 16'(brightness);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // floor(p / 255) = (p + 1 + p / 256) / 256 for p up to 255*255, sum stays below 2^16
   assign quot_sum = prod_ff + 16'd1 + {8'd0, prod_ff[15:8]};
   assign scaled   = quot_sum[15:8];

   // four spi bytes for the scaled value
   assign enc_word = encode_color(scaled);

endmodule

@@ src/wsenc_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsenc_merge
// Collects the three lane words of a pixel and sends them out in wire order.
// ----------------------------------------------------------------------------
module wsenc_merge
   import wsenc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           lane_valid,
   input  word_array_type lane_words,
   output logic           load,
   wsenc_rsp_if.source    rsp
);

   word_type   pending_words_ff [NUM_CH];
   logic [1:0] word_cnt_ff;
   logic [1:0] word_cnt_in;
   logic       busy_ff;
   logic       busy_in;
   logic       last_taken;

   // the last word of the held pixel leaves this cycle
   assign last_taken = busy_ff && rsp.ready && (word_cnt_ff == CH_BLUE);

   // take a new pixel when empty or when the held one is finishing
   assign load = lane_valid && (!busy_ff || last_taken);

   // word counter and busy flag
   always_comb begin
      busy_in     = busy_ff;
      word_cnt_in = word_cnt_ff;
      if (load) begin
         busy_in     = 1'b1;
         word_cnt_in = CH_GREEN;
      end else if (busy_ff && rsp.ready) begin
         if (word_cnt_ff == CH_BLUE) begin
            busy_in     = 1'b0;
            word_cnt_in = CH_GREEN;
         end else begin
            word_cnt_in = word_cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         word_cnt_ff <= CH_GREEN;
      end else begin
         busy_ff     <= busy_in;
         word_cnt_ff <= word_cnt_in;
      end
   end

   // pending words of the current pixel
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < NUM_CH; i++) begin
            pending_words_ff[i] <= lane_words[i];
         end
      end
   end

   // output word
   assign rsp.valid         = busy_ff;
   assign rsp.spi_word      = pending_words_ff[word_cnt_ff];
   assign rsp.channel       = word_cnt_ff;
   assign rsp.last_of_pixel = (word_cnt_ff == CH_BLUE);

endmodule

@@ src/ws2812_spi_pixel_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ws2812_spi_pixel_encoder
// Scales an rgb pixel by brightness and encodes it as three spi symbol words.
// ----------------------------------------------------------------------------
//  channel  | dir | word contents                          | accepted when
//  ---------+-----+----------------------------------------+----------------
//  req_ch   | in  | red, green, blue (8 bits each)         | valid && ready
//  rsp_ch   | out | spi_word, channel, last_of_pixel       | valid && ready
//  csr_ch   | in  | brightness (8 bits)                    | valid && ready
//
//  A pixel gives three words (green, red, blue) on consecutive cycles while
//  rsp_ch.ready is high; the single output word port sets the sustained
//  pixel rate. A pixel is registered in the lane stage and then in the merge stage before its first word goes out.
//  The three color lanes work in parallel; the merge stage holds one pixel
//  while the lanes hold the next. Reset sets brightness to 40 and empties
//  both stages. csr_ch is always ready.
// ----------------------------------------------------------------------------
module ws2812_spi_pixel_encoder
   import wsenc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   wsenc_req_if.sink   req_ch,
   wsenc_rsp_if.source rsp_ch,
   wsenc_csr_if.sink   csr_ch
);

   color_type      bright_ff;
   color_type      bright_in;
   logic           lane_valid_ff;
   logic           lane_valid_in;
   logic           req_take;
   logic           merge_load;
   color_type      lane_chan [NUM_CH];
   word_array_type lane_words;

   // brightness register
   assign csr_ch.ready = 1'b1;
   assign bright_in    = csr_ch.valid ? csr_ch.brightness : bright_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= BRIGHT_RESET;
      end else begin
         bright_ff <= bright_in;
      end
   end

   // lane stage occupancy
   assign req_ch.ready  = !lane_valid_ff || merge_load;
   assign req_take      = req_ch.valid && req_ch.ready;
   assign lane_valid_in = req_take ? 1'b1 : (merge_load ? 1'b0 : lane_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
      end else begin
         lane_valid_ff <= lane_valid_in;
      end
   end

   // lanes in wire order
   assign lane_chan[CH_GREEN] = req_ch.green;
   assign lane_chan[CH_RED]   = req_ch.red;
   assign lane_chan[CH_BLUE]  = req_ch.blue;

   for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
      wsenc_lane u_lane (
         .clock      (clock),
         .load       (req_take),
         .chan_value (lane_chan[g]),
         .brightness (bright_ff),
         .enc_word   (lane_words[g])
      );
   end

   // merge and send
   wsenc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .lane_valid (lane_valid_ff),
      .lane_words (lane_words),
      .load       (merge_load),
      .rsp        (rsp_ch)
   );

endmodule

@@ src/wsenc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsenc_checker
// Port-level checks of the word sequence of the pixel encoder.
// ----------------------------------------------------------------------------
module wsenc_checker
   import wsenc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_spi_word,
   input logic [1:0]  rsp_channel,
   input logic        rsp_last_of_pixel
);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_spi_word)
         && $stable(rsp_channel))
      else $error("stalled word changed");

   // flag marks exactly the blue word, and channel code 3 never shows
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_pixel == (rsp_channel == CH_BLUE))
         && (rsp_channel != 2'd3))
      else $error("bad channel code or last flag");

   // green is followed at once by red
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_channel == CH_GREEN |=>
         rsp_valid && rsp_channel == CH_RED)
      else $error("red word did not follow green");

   // red is followed at once by blue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_channel == CH_RED |=>
         rsp_valid && rsp_channel == CH_BLUE)
      else $error("blue word did not follow red");

endmodule

bind ws2812_spi_pixel_encoder wsenc_checker u_wsenc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_spi_word      (rsp_ch.spi_word),
   .rsp_channel       (rsp_ch.channel),
   .rsp_last_of_pixel (rsp_ch.last_of_pixel)
);
